FILE: src/ascp_pkg.sv
package ascp_pkg;

    // Parser phase within one sequence
    typedef enum logic [2:0] {
        PH_ESC     = 3'd0,
        PH_BRACKET = 3'd1,
        PH_PARSE   = 3'd2,
        PH_DONE    = 3'd3,
        PH_REJECT  = 3'd4
    } phase_t;

    // Attribute updates collected while a sequence is parsed
    typedef struct packed {
        logic       bold;
        logic [2:0] fore;
        logic [2:0] back;
        logic       report;
    } pend_t;

    // Characters of interest
    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_BRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // SGR codes
    localparam logic [7:0] SGR_RESET  = 8'd0;
    localparam logic [7:0] SGR_BOLD   = 8'd1;
    localparam logic [7:0] SGR_REPORT = 8'd6;
    localparam logic [7:0] SGR_FG_LO  = 8'd30;
    localparam logic [7:0] SGR_FG_HI  = 8'd37;
    localparam logic [7:0] SGR_BG_LO  = 8'd40;
    localparam logic [7:0] SGR_BG_HI  = 8'd47;
    localparam logic [7:0] CODE_MAX   = 8'd255;
    localparam logic [3:0] DEC_BASE   = 4'd10;

    // Register map
    localparam logic [1:0]  ADDR_COLOR_MAP = 2'd0;
    localparam logic [23:0] COLOR_MAP_RST  = 24'hEE9CA0;

    // Committed attribute reset: map entry seven on map entry zero
    localparam logic [2:0] FORE_RST = 3'd7;
    localparam logic [2:0] BACK_RST = 3'd0;
    localparam logic [2:0] DEF_FORE_IDX = 3'd7;
    localparam logic [2:0] DEF_BACK_IDX = 3'd0;

    localparam logic [6:0] ATTR_BOLD = 7'h08;

endpackage

FILE: src/ansi_sgr_color_parser.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | seq_byte[7:0], last_byte
// out     | output    | out_valid/out_ready| attribute[6:0], seq_valid, report_requested
// apb     | input     | psel/penable/pready| paddr[1:0], pwdata/prdata[31:0]
//
// One beat per cycle unless a waiting result holds a last byte: a byte sits in the input
// register while its parser update settles, and the result register loads from that
// update when the last byte steps, so a result follows its last byte through the input and
// result registers; one byte per cycle is set by the single parser step between them.
// Reset (rst_n, async) empties both registers and restores the attributes.
// A waiting result stalls only a following last byte; other bytes keep flowing.
module ansi_sgr_color_parser
    import ascp_pkg::*;
#(
    parameter int SEQ_LIMIT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  seq_byte,
    input  logic        last_byte,
    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  attribute,
    output logic        seq_valid,
    output logic        report_requested,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [8:0] LEN_LIMIT = 9'(SEQ_LIMIT - 1);

    // Configuration register
    logic [23:0] color_map_reg;

    // Input register
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  count_reg, count_next;
    logic        bold_reg, bold_next;
    logic [2:0]  fore_reg, fore_next;
    logic [2:0]  back_reg, back_next;
    pend_t       pend_reg, pend_next;

    // Result register
    logic        out_valid_reg;
    logic [6:0]  attribute_reg, attribute_next;
    logic        seq_valid_reg, seq_valid_next;
    logic        report_reg, report_next;

    logic        s1_go;
    logic        step;
    logic        is_digit;
    logic [11:0] acc_sum;
    logic [8:0]  seq_len;
    logic        commit;
    pend_t       pend_base;
    pend_t       pend_mid;
    logic [6:0]  attr_raw;

    function automatic logic [2:0] map_entry(logic [23:0] cmap, logic [2:0] idx);
        return cmap[3*idx +: 3];
    endfunction

    // Apply one finished SGR code to the pending attributes
    function automatic pend_t apply_code(pend_t p, logic [7:0] code, logic term_n,
                                         logic [23:0] cmap);
        pend_t r;
        r = p;
        if (code == SGR_RESET) begin
            r.bold = 1'b0;
            r.fore = map_entry(cmap, DEF_FORE_IDX);
            r.back = map_entry(cmap, DEF_BACK_IDX);
        end
        else if (code == SGR_BOLD) begin
            r.bold = 1'b1;
        end
        else if (code == SGR_REPORT) begin
            if (term_n)
                r.report = 1'b1;
        end
        else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
            r.fore = map_entry(cmap, 3'(code - SGR_FG_LO));
        end
        else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
            r.back = map_entry(cmap, 3'(code - SGR_BG_LO));
        end
        return r;
    endfunction

    // Handshakes: the parser step moves on unless a result would be blocked
    assign s1_go    = !s1_last_reg || !out_valid_reg || out_ready;
    assign step     = s1_valid_reg && s1_go;
    assign in_ready = !s1_valid_reg || s1_go;

    // APB register port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_COLOR_MAP) ? {8'b0, color_map_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            color_map_reg <= COLOR_MAP_RST;
        else if (psel && penable && pwrite && paddr == ADDR_COLOR_MAP)
            color_map_reg <= pwdata[23:0];
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= seq_byte;
            s1_last_reg <= last_byte;
        end
    end

    // Parser step
    assign is_digit = s1_byte_reg >= CH_ZERO && s1_byte_reg <= CH_NINE;
    assign acc_sum  = {4'b0, code_reg} * {8'b0, DEC_BASE} + {8'b0, s1_byte_reg[3:0]};
    assign seq_len  = {1'b0, count_reg} + 9'd1;

    always_comb
    begin
        phase_next = phase_reg;
        code_next  = code_reg;
        pend_base  = pend_reg;
        if (phase_reg == PH_ESC)
        begin
            pend_base.bold   = bold_reg;
            pend_base.fore   = fore_reg;
            pend_base.back   = back_reg;
            pend_base.report = 1'b0;
        end
        pend_mid = pend_base;

        case (phase_reg)
            PH_ESC:
            begin
                code_next  = 8'd0;
                phase_next = (s1_byte_reg == CH_ESC) ? PH_BRACKET : PH_REJECT;
            end
            PH_BRACKET:
            begin
                code_next  = 8'd0;
                phase_next = (s1_byte_reg == CH_BRACKET) ? PH_PARSE : PH_REJECT;
            end
            PH_PARSE:
            begin
                if (is_digit)
                begin
                    code_next = (acc_sum > {4'b0, CODE_MAX}) ? CODE_MAX : acc_sum[7:0];
                end
                else
                begin
                    pend_mid  = apply_code(pend_base, code_reg, s1_byte_reg == CH_N,
                                           color_map_reg);
                    code_next = 8'd0;
                    if (s1_byte_reg != CH_SEMI)
                        phase_next = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        count_next = (count_reg == CODE_MAX) ? count_reg : count_reg + 8'd1;
        pend_next  = pend_mid;
        bold_next  = bold_reg;
        fore_next  = fore_reg;
        back_next  = back_reg;
        commit     = 1'b0;
        attr_raw   = 7'd0;
        attribute_next = 7'd0;
        seq_valid_next = 1'b0;
        report_next    = 1'b0;

        // End of sequence: flush an open code, then commit or reject
        if (s1_last_reg)
        begin
            if (phase_next == PH_PARSE)
                pend_next = apply_code(pend_mid, code_next, 1'b0, color_map_reg);
            commit = (phase_next == PH_PARSE || phase_next == PH_DONE) &&
                     seq_len < LEN_LIMIT;
            if (commit)
            begin
                bold_next = pend_next.bold;
                fore_next = pend_next.fore;
                back_next = pend_next.back;
                attr_raw  = {pend_next.back, pend_next.bold, pend_next.fore};
                attribute_next = (attr_raw == 7'd0) ? ATTR_BOLD : attr_raw;
                seq_valid_next = 1'b1;
                report_next    = pend_next.report;
            end
            phase_next = PH_ESC;
            code_next  = 8'd0;
            count_next = 8'd0;
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ESC;
            code_reg  <= 8'd0;
            count_reg <= 8'd0;
            bold_reg  <= 1'b0;
            fore_reg  <= FORE_RST;
            back_reg  <= BACK_RST;
            pend_reg  <= '{bold: 1'b0, fore: FORE_RST, back: BACK_RST, report: 1'b0};
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            code_reg  <= code_next;
            count_reg <= count_next;
            bold_reg  <= bold_next;
            fore_reg  <= fore_next;
            back_reg  <= back_next;
            pend_reg  <= pend_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && s1_last_reg)
        begin
            attribute_reg <= attribute_next;
            seq_valid_reg <= seq_valid_next;
            report_reg    <= report_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign attribute        = attribute_reg;
    assign seq_valid        = seq_valid_reg;
    assign report_requested = report_reg;

endmodule

FILE: src/ascp_checker.sv
module ascp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] attribute,
    input logic       seq_valid,
    input logic       report_requested,
    input logic       pready
);

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(attribute) &&
                                    $stable(seq_valid) && $stable(report_requested))
        else $error("result beat changed while stalled");

    // Rejected sequences carry no attribute and no report
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !seq_valid |-> attribute == 7'd0 && !report_requested)
        else $error("rejected sequence carries data");

    // Black on black is never shown for a valid sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seq_valid |-> attribute != 7'd0)
        else $error("valid sequence gave a zero attribute");

    // Register port never waits
    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind ansi_sgr_color_parser ascp_checker u_ascp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .attribute        (attribute),
    .seq_valid        (seq_valid),
    .report_requested (report_requested),
    .pready           (pready)
);
